@@ src/sseenc_pkg.sv @@
`timescale 1ns / 1ps

package sseenc_pkg;

   // Operation kinds carried on the request channel; codes 12 to 15 are undefined.
   localparam logic [3:0] KIND_ALLOC     = 4'd0;
   localparam logic [3:0] KIND_RELEASE   = 4'd1;
   localparam logic [3:0] KIND_STORE     = 4'd2;
   localparam logic [3:0] KIND_LOAD      = 4'd3;
   localparam logic [3:0] KIND_ADD       = 4'd4;
   localparam logic [3:0] KIND_SUB       = 4'd5;
   localparam logic [3:0] KIND_MUL       = 4'd6;
   localparam logic [3:0] KIND_DIV       = 4'd7;
   localparam logic [3:0] KIND_SQRT      = 4'd8;
   localparam logic [3:0] KIND_COPY      = 4'd9;
   localparam logic [3:0] KIND_LOADCONST = 4'd10;
   localparam logic [3:0] KIND_RETURN    = 4'd11;

   // Configuration register indexes.
   localparam logic [7:0] CSR_CONST_BASE  = 8'd0;
   localparam logic [7:0] CSR_FRAME_BYTES = 8'd1;

   localparam logic [15:0] CONST_BASE_RESET  = 16'd2048;
   localparam logic [15:0] FRAME_BYTES_RESET = 16'd512;

   localparam int CONST_SLOTS_DEFAULT = 16;

   // Fixed encoding bytes.
   localparam logic [7:0] BYTE_REX_W     = 8'h48;
   localparam logic [7:0] BYTE_GRP1_IMM  = 8'h81;
   localparam logic [7:0] BYTE_MODRM_RSP = 8'hEC;
   localparam logic [7:0] BYTE_MODRM_ADD = 8'hC4;
   localparam logic [7:0] BYTE_PFX_F3    = 8'hF3;
   localparam logic [7:0] BYTE_ESC_0F    = 8'h0F;
   localparam logic [7:0] OP_MOVSS_ST    = 8'h11;
   localparam logic [7:0] OP_MOVSS_LD    = 8'h10;
   localparam logic [7:0] OP_ADDSS       = 8'h58;
   localparam logic [7:0] OP_SUBSS       = 8'h5C;
   localparam logic [7:0] OP_MULSS       = 8'h59;
   localparam logic [7:0] OP_DIVSS       = 8'h5E;
   localparam logic [7:0] OP_SQRTSS      = 8'h51;
   localparam logic [7:0] BYTE_SIB_RSP   = 8'h24;
   localparam logic [7:0] BYTE_RET       = 8'hC3;
   localparam logic [1:0] MOD_DISP32     = 2'b10;
   localparam logic [1:0] MOD_REG        = 2'b11;
   localparam logic [2:0] RM_SIB         = 3'b100;
   localparam logic [2:0] RM_RIP         = 3'b101;

   // Third opcode byte of the register-to-register kinds.
   function automatic logic [7:0] arith_opcode(input logic [3:0] kind);
      logic [7:0] op;
      op = OP_MOVSS_LD;
      case (kind)
         KIND_ADD:  op = OP_ADDSS;
         KIND_SUB:  op = OP_SUBSS;
         KIND_MUL:  op = OP_MULSS;
         KIND_DIV:  op = OP_DIVSS;
         KIND_SQRT: op = OP_SQRTSS;
         default:   op = OP_MOVSS_LD;
      endcase
      return op;
   endfunction

endpackage

@@ src/sse_scalar_instruction_encoder.sv @@
`timescale 1ns / 1ps

// Scalar SSE instruction encoder.
// Each request transfer names one operation (kind on req_tuser, operands on
// req_tdata); the block answers with the instruction's machine code, one byte
// per response transfer. Every byte carries its position in the code area from
// a running 16-bit count, rsp_tlast marks the final byte of an instruction and
// rsp_tuser flags an undefined kind, which gives a single zero byte and leaves
// the count alone. The csr_ channel writes the constant pool base and the frame
// size; it is always ready. The user must write it only while the block is idle;
// the block itself does not enforce this. A request is captured in the request
// register and its first byte is generated from there into the response register.
// Throughput: one byte per cycle while the receiver does not stall, and a request
// has one to nine bytes; the single byte generator behind the request register
// sets this rate. The next request is taken in the cycle its predecessor's last byte is
// generated, so requests follow each other without gaps.
// Reset clears the byte count, restores the register defaults and empties the
// request and response registers. When the receiver stalls the response register
// holds its byte, generation pauses and the request channel stalls in turn.
module sse_scalar_instruction_encoder #(
   parameter int CONST_SLOTS = sseenc_pkg::CONST_SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // reg_a[2:0], reg_b[5:3], mem_offset[37:6],
                                    // const_index[41:38], zero fill[47:42]
   input  logic [3:0]  req_tuser,   // kind[3:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // code_byte[7:0], byte_offset[23:8]
   output logic        rsp_tlast,   // last
   output logic        rsp_tuser,   // error[0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int SLOT_W = (CONST_SLOTS > 1) ? $clog2(CONST_SLOTS) : 1;

   // Constant table: pool slot for every value of const_index.
   logic [SLOT_W-1:0] slot_table [16];

   for (genvar v = 0; v < 16; v++) begin : g_slot
      localparam int SLOT = v % CONST_SLOTS;
      assign slot_table[v] = SLOT_W'(SLOT);
   end

   logic [15:0] const_base_ff;
   logic [15:0] frame_bytes_ff;
   logic [15:0] count_ff,     count_in;

   logic        item_valid_ff, item_valid_in;
   logic [3:0]  kind_ff;
   logic [2:0]  reg_a_ff;
   logic [2:0]  reg_b_ff;
   logic [31:0] mem_offset_ff;
   logic [3:0]  const_index_ff;
   logic [3:0]  idx_ff,       idx_in;
   logic [31:0] word_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  code_byte_ff;
   logic [15:0] byte_offset_ff;
   logic        last_ff;
   logic        error_ff;

   logic        req_fire;
   logic        gen_go;
   logic [7:0]  gen_byte;
   logic        gen_last;
   logic        gen_err;
   logic [31:0] word_now;
   logic [31:0] word_sel;
   logic [3:0]  word_base;
   logic [3:0]  word_pos;
   logic [16:0] frame_rounded;
   logic [31:0] disp;
   logic [2:0]  rm_field;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         const_base_ff  <= sseenc_pkg::CONST_BASE_RESET;
         frame_bytes_ff <= sseenc_pkg::FRAME_BYTES_RESET;
      end else if (csr_valid) begin
         if (csr_index == sseenc_pkg::CSR_CONST_BASE) begin
            const_base_ff <= csr_data;
         end else if (csr_index == sseenc_pkg::CSR_FRAME_BYTES) begin
            frame_bytes_ff <= csr_data;
         end
      end
   end

   // Byte generation runs whenever an item is held and the response register is free.
   assign gen_go     = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || (gen_go && gen_last);
   assign req_fire   = req_tvalid && req_tready;

   assign frame_rounded = ({1'b0, frame_bytes_ff} + 17'd15) & ~17'd15;
   assign disp = {16'd0, const_base_ff} + {22'd0, 8'(slot_table[const_index_ff]), 2'b00}
                 - {16'd0, count_ff} - 32'd8;
   assign rm_field = (kind_ff == sseenc_pkg::KIND_SQRT) ? reg_a_ff : reg_b_ff;

   // The 32-bit tail word is captured on the first byte; later bytes pick from it.
   assign word_pos = idx_ff - word_base;
   assign word_sel = word_ff >> {word_pos[1:0], 3'b000};

   always_comb begin
      gen_byte  = '0;
      gen_last  = 1'b0;
      gen_err   = 1'b0;
      word_now  = '0;
      word_base = 4'd3;
      case (kind_ff)
         sseenc_pkg::KIND_ALLOC, sseenc_pkg::KIND_RELEASE: begin
            word_now  = {15'd0, frame_rounded};
            word_base = 4'd3;
            gen_last  = (idx_ff == 4'd6);
            case (idx_ff)
               4'd0:    gen_byte = sseenc_pkg::BYTE_REX_W;
               4'd1:    gen_byte = sseenc_pkg::BYTE_GRP1_IMM;
               4'd2:    gen_byte = (kind_ff == sseenc_pkg::KIND_ALLOC) ?
                                   sseenc_pkg::BYTE_MODRM_RSP : sseenc_pkg::BYTE_MODRM_ADD;
               default: gen_byte = word_sel[7:0];
            endcase
         end
         sseenc_pkg::KIND_STORE, sseenc_pkg::KIND_LOAD: begin
            word_now  = mem_offset_ff;
            word_base = 4'd5;
            gen_last  = (idx_ff == 4'd8);
            case (idx_ff)
               4'd0:    gen_byte = sseenc_pkg::BYTE_PFX_F3;
               4'd1:    gen_byte = sseenc_pkg::BYTE_ESC_0F;
               4'd2:    gen_byte = (kind_ff == sseenc_pkg::KIND_STORE) ?
                                   sseenc_pkg::OP_MOVSS_ST : sseenc_pkg::OP_MOVSS_LD;
               4'd3:    gen_byte = {sseenc_pkg::MOD_DISP32, reg_a_ff, sseenc_pkg::RM_SIB};
               4'd4:    gen_byte = sseenc_pkg::BYTE_SIB_RSP;
               default: gen_byte = word_sel[7:0];
            endcase
         end
         sseenc_pkg::KIND_ADD, sseenc_pkg::KIND_SUB, sseenc_pkg::KIND_MUL,
         sseenc_pkg::KIND_DIV, sseenc_pkg::KIND_SQRT, sseenc_pkg::KIND_COPY: begin
            gen_last = (idx_ff == 4'd3);
            case (idx_ff)
               4'd0:    gen_byte = sseenc_pkg::BYTE_PFX_F3;
               4'd1:    gen_byte = sseenc_pkg::BYTE_ESC_0F;
               4'd2:    gen_byte = sseenc_pkg::arith_opcode(kind_ff);
               default: gen_byte = {sseenc_pkg::MOD_REG, reg_a_ff, rm_field};
            endcase
         end
         sseenc_pkg::KIND_LOADCONST: begin
            word_now  = disp;
            word_base = 4'd4;
            gen_last  = (idx_ff == 4'd7);
            case (idx_ff)
               4'd0:    gen_byte = sseenc_pkg::BYTE_PFX_F3;
               4'd1:    gen_byte = sseenc_pkg::BYTE_ESC_0F;
               4'd2:    gen_byte = sseenc_pkg::OP_MOVSS_LD;
               4'd3:    gen_byte = {2'b00, reg_b_ff, sseenc_pkg::RM_RIP};
               default: gen_byte = word_sel[7:0];
            endcase
         end
         sseenc_pkg::KIND_RETURN: begin
            gen_byte = sseenc_pkg::BYTE_RET;
            gen_last = 1'b1;
         end
         default: begin
            gen_last = 1'b1;
            gen_err  = 1'b1;
         end
      endcase
   end

   always_comb begin
      item_valid_in = item_valid_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      if (gen_go) begin
         rsp_valid_in = 1'b1;
         idx_in       = gen_last ? 4'd0 : idx_ff + 4'd1;
         if (!gen_err) begin
            count_in = count_ff + 16'd1;
         end
         if (gen_last) begin
            item_valid_in = 1'b0;
         end
      end
      if (req_fire) begin
         item_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         idx_ff        <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         idx_ff        <= idx_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff        <= req_tuser;
         reg_a_ff       <= req_tdata[2:0];
         reg_b_ff       <= req_tdata[5:3];
         mem_offset_ff  <= req_tdata[37:6];
         const_index_ff <= req_tdata[41:38];
      end
      if (gen_go && idx_ff == 4'd0) begin
         word_ff <= word_now;
      end
      if (gen_go) begin
         code_byte_ff   <= gen_byte;
         byte_offset_ff <= count_ff;
         last_ff        <= gen_last;
         error_ff       <= gen_err;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {byte_offset_ff, code_byte_ff};
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = error_ff;

endmodule
